### rtl/brb_pkg.sv
// brb_pkg: shared types, field widths and codes for the byte ring buffer
package brb_pkg;

    // field widths
    localparam int CMD_W  = 3;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 2;
    localparam int FILL_W = 8;
    localparam int PTR_W  = 8;
    localparam int SIZE_W = 9;

    // largest ring the pointers can address
    localparam int RING_MAX = 256;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BURST  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REWIND = 3'd4;

    // status codes on the output channel
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // input transaction payload
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data_in;
        logic [CNT_W-1:0]  count;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [STAT_W-1:0] status;
        logic              last;
        logic [FILL_W-1:0] fill_level;
    } t_out_item;

    // decoded operation kinds
    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_PEEK   = 3'd1,
        OP_POP    = 3'd2,
        OP_BURST  = 3'd3,
        OP_REWIND = 3'd4
    } t_op_kind;

    // classified operation held in the queue
    typedef struct packed {
        t_op_kind          kind;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              burst_zero;
        logic              burst_over;
    } t_op;

endpackage

### rtl/byte_ring_buffer_peek_rewind_core.sv
// byte_ring_buffer_peek_rewind_core: circular byte buffer with peek, pop, burst and rewind
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+---------------------------
//   in       | input     | i_in_valid / o_in_ready  | i_in  (cmd, data_in, count)
//   out      | output    | o_out_valid / i_out_ready| o_out (data_out, status, last,
//            |           |                          |        fill_level)
//   cfg      | input     | i_cfg_we, no wait        | i_cfg_data (ring_size)
//
// write, empty peek/pop and refused burst: result registered from idle; peek and pop
// with data: registered ram read, then result; a burst: one byte per cycle from the ram
// read port unless the output stalls; rewind: bit-serial remainder, pointer move, result.
// reset is synchronous, empties the ring and sets the full ring size; no clearing pass.
// a two-entry queue decouples input from execution; a stalled output holds result steps.
module byte_ring_buffer_peek_rewind_core #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [brb_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  brb_pkg::t_in_item          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output brb_pkg::t_out_item         o_out
);

    localparam int MEM_DEPTH = (DEPTH < brb_pkg::RING_MAX) ? DEPTH : brb_pkg::RING_MAX;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic                       w_q_full;
    logic                       w_push;
    brb_pkg::t_op               w_op;
    logic                       w_head_vld;
    brb_pkg::t_op               w_head;
    logic                       w_pop;
    logic                       w_ram_we;
    logic [AW-1:0]              w_ram_waddr;
    logic [brb_pkg::DATA_W-1:0] w_ram_wdata;
    logic                       w_ram_re;
    logic [AW-1:0]              w_ram_raddr;
    logic [brb_pkg::DATA_W-1:0] w_ram_rdata;

    // accept and classify
    brb_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_op       (w_op)
    );

    // operation queue
    brb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_op       (w_op),
        .o_full     (w_q_full),
        .o_head_vld (w_head_vld),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // execution and result register
    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_head_vld  (w_head_vld),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // byte store
    brb_ram #(
        .WIDTH (brb_pkg::DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

### rtl/brb_ram.sv
// brb_ram: generic single write port, single read port ram with registered read
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/brb_front.sv
// brb_front: input handshake and command classification
module brb_front #(
    parameter int MAX_BURST = 64
) (
    input  logic              i_in_valid,
    input  brb_pkg::t_in_item i_in,
    output logic              o_in_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output brb_pkg::t_op      o_op
);

    logic w_known;

    // take a transaction whenever the queue has room
    assign o_in_ready = !i_q_full;

    // decode the command, unknown codes are dropped
    always_comb begin
        w_known         = 1'b1;
        o_op.kind       = brb_pkg::OP_WRITE;
        o_op.data       = i_in.data_in;
        o_op.count      = i_in.count;
        o_op.burst_zero = (i_in.count == '0);
        o_op.burst_over = (i_in.count > brb_pkg::CNT_W'(MAX_BURST));
        unique case (i_in.cmd)
            brb_pkg::CMD_WRITE:  o_op.kind = brb_pkg::OP_WRITE;
            brb_pkg::CMD_PEEK:   o_op.kind = brb_pkg::OP_PEEK;
            brb_pkg::CMD_POP:    o_op.kind = brb_pkg::OP_POP;
            brb_pkg::CMD_BURST:  o_op.kind = brb_pkg::OP_BURST;
            brb_pkg::CMD_REWIND: o_op.kind = brb_pkg::OP_REWIND;
            default:             w_known   = 1'b0;
        endcase
    end

    assign o_push = i_in_valid && o_in_ready && w_known;

endmodule

### rtl/brb_queue.sv
// brb_queue: two-entry queue of classified operations between front and back
module brb_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  brb_pkg::t_op i_op,
    output logic         o_full,
    output logic         o_head_vld,
    output brb_pkg::t_op o_head,
    input  logic         i_pop
);

    brb_pkg::t_op r_slot [2];
    logic         r_wsel;
    logic         r_rsel;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_full     = (r_cnt == 2'd2);
    assign o_head_vld = (r_cnt != 2'd0);
    assign o_head     = r_slot[r_rsel];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_head_vld;

    // slot payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wsel] <= i_op;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsel <= 1'b0;
            r_rsel <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wsel <= !r_wsel;
            end
            if (w_pop) begin
                r_rsel <= !r_rsel;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/brb_back.sv
// brb_back: pointer state, command execution and result register
module brb_back #(
    parameter int DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [brb_pkg::SIZE_W-1:0]         i_cfg_data,
    input  logic                               i_head_vld,
    input  brb_pkg::t_op                       i_head,
    output logic                               o_pop,
    output logic                               o_ram_we,
    output logic [$clog2((DEPTH < brb_pkg::RING_MAX) ? DEPTH : brb_pkg::RING_MAX)-1:0] o_ram_waddr,
    output logic [brb_pkg::DATA_W-1:0]         o_ram_wdata,
    output logic                               o_ram_re,
    output logic [$clog2((DEPTH < brb_pkg::RING_MAX) ? DEPTH : brb_pkg::RING_MAX)-1:0] o_ram_raddr,
    input  logic [brb_pkg::DATA_W-1:0]         i_ram_rdata,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output brb_pkg::t_out_item                 o_out
);

    localparam int MAX_N = (DEPTH < brb_pkg::RING_MAX) ? DEPTH : brb_pkg::RING_MAX;
    localparam int AW    = $clog2(MAX_N);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_BURST = 6'b000100,
        S_MOD   = 6'b001000,
        S_MOVE  = 6'b010000,
        S_RWOUT = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [brb_pkg::SIZE_W-1:0] r_size;
    logic [brb_pkg::PTR_W-1:0]  r_rp, n_rp;
    logic [brb_pkg::PTR_W-1:0]  r_wp, n_wp;
    logic [brb_pkg::CNT_W-1:0]  r_left, n_left;
    logic [brb_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [brb_pkg::CNT_W-1:0]  r_rem, n_rem;
    logic [2:0]                 r_bit, n_bit;
    logic                       r_is_pop, n_is_pop;
    logic                       r_out_vld, n_out_vld;
    brb_pkg::t_out_item         r_out, n_out;

    logic [brb_pkg::SIZE_W-1:0] w_cfg_size;
    logic [brb_pkg::SIZE_W-1:0] w_fill_wide;
    logic [brb_pkg::FILL_W-1:0] w_fill;
    logic [brb_pkg::PTR_W-1:0]  w_rp_bump;
    logic [brb_pkg::PTR_W-1:0]  w_wp_bump;
    logic [brb_pkg::DATA_W-1:0] w_trial;
    logic [brb_pkg::SIZE_W-1:0] w_rem_ext;
    logic                       w_can_emit;

    // clamp the written ring size to the usable range
    always_comb begin
        if (i_cfg_data < brb_pkg::SIZE_W'(2)) begin
            w_cfg_size = brb_pkg::SIZE_W'(2);
        end else if (i_cfg_data > brb_pkg::SIZE_W'(MAX_N)) begin
            w_cfg_size = brb_pkg::SIZE_W'(MAX_N);
        end else begin
            w_cfg_size = i_cfg_data;
        end
    end

    // fill level from the pointers
    always_comb begin
        if (r_wp >= r_rp) begin
            w_fill_wide = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            w_fill_wide = {1'b0, r_wp} + r_size - {1'b0, r_rp};
        end
    end
    assign w_fill = w_fill_wide[brb_pkg::FILL_W-1:0];

    // pointer increment with wrap at the ring size
    assign w_rp_bump = (({1'b0, r_rp} + 9'd1) >= r_size) ? '0 : r_rp + 8'd1;
    assign w_wp_bump = (({1'b0, r_wp} + 9'd1) >= r_size) ? '0 : r_wp + 8'd1;

    // remainder step: bring down one count bit
    assign w_trial   = {r_rem, r_cnt[r_bit]};
    assign w_rem_ext = {2'b00, r_rem};

    assign w_can_emit  = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // memory ports
    assign o_ram_waddr = r_wp[AW-1:0];
    assign o_ram_wdata = i_head.data;

    // command sequencer
    always_comb begin
        n_state   = r_state;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_left    = r_left;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_bit     = r_bit;
        n_is_pop  = r_is_pop;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        o_pop     = 1'b0;
        o_ram_we  = 1'b0;
        o_ram_re  = 1'b0;
        o_ram_raddr = r_rp[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_head_vld) begin
                    case (i_head.kind)
                        brb_pkg::OP_WRITE: begin
                            if (w_can_emit) begin
                                o_pop     = 1'b1;
                                n_out_vld = 1'b1;
                                n_out.data_out = '0;
                                n_out.last     = 1'b1;
                                if (w_fill_wide >= r_size - 9'd1) begin
                                    n_out.status     = brb_pkg::ST_FULL;
                                    n_out.fill_level = w_fill;
                                end else begin
                                    o_ram_we         = 1'b1;
                                    n_wp             = w_wp_bump;
                                    n_out.status     = brb_pkg::ST_OK;
                                    n_out.fill_level = w_fill + 8'd1;
                                end
                            end
                        end
                        brb_pkg::OP_PEEK, brb_pkg::OP_POP: begin
                            if (w_fill == '0) begin
                                if (w_can_emit) begin
                                    o_pop     = 1'b1;
                                    n_out_vld = 1'b1;
                                    n_out.data_out   = '0;
                                    n_out.status     = brb_pkg::ST_SHORT;
                                    n_out.last       = 1'b1;
                                    n_out.fill_level = '0;
                                end
                            end else begin
                                o_pop    = 1'b1;
                                o_ram_re = 1'b1;
                                n_is_pop = (i_head.kind == brb_pkg::OP_POP);
                                n_state  = S_READ;
                            end
                        end
                        brb_pkg::OP_BURST: begin
                            if (i_head.burst_zero || i_head.burst_over ||
                                ({1'b0, i_head.count} > w_fill)) begin
                                if (w_can_emit) begin
                                    o_pop     = 1'b1;
                                    n_out_vld = 1'b1;
                                    n_out.data_out   = '0;
                                    n_out.status     = i_head.burst_zero ? brb_pkg::ST_OK
                                                                         : brb_pkg::ST_SHORT;
                                    n_out.last       = 1'b1;
                                    n_out.fill_level = w_fill;
                                end
                            end else begin
                                o_pop    = 1'b1;
                                o_ram_re = 1'b1;
                                n_left   = i_head.count;
                                n_state  = S_BURST;
                            end
                        end
                        brb_pkg::OP_REWIND: begin
                            o_pop   = 1'b1;
                            n_cnt   = i_head.count;
                            n_rem   = '0;
                            n_bit   = 3'(brb_pkg::CNT_W - 1);
                            n_state = S_MOD;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            // single byte read, data is in the ram output register
            S_READ: begin
                if (w_can_emit) begin
                    n_out_vld = 1'b1;
                    n_out.data_out = i_ram_rdata;
                    n_out.status   = brb_pkg::ST_OK;
                    n_out.last     = 1'b1;
                    if (r_is_pop) begin
                        n_rp             = w_rp_bump;
                        n_out.fill_level = w_fill - 8'd1;
                    end else begin
                        n_out.fill_level = w_fill;
                    end
                    n_state = S_IDLE;
                end
            end
            // one byte per cycle while the output is not stalled, next read issued as each result goes out
            S_BURST: begin
                if (w_can_emit) begin
                    n_out_vld = 1'b1;
                    n_out.data_out   = i_ram_rdata;
                    n_out.status     = brb_pkg::ST_OK;
                    n_out.last       = (r_left == brb_pkg::CNT_W'(1));
                    n_out.fill_level = w_fill - 8'd1;
                    n_rp             = w_rp_bump;
                    n_left           = r_left - brb_pkg::CNT_W'(1);
                    if (r_left == brb_pkg::CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = w_rp_bump[AW-1:0];
                    end
                end
            end
            // restoring remainder of count by ring size, one bit a cycle
            S_MOD: begin
                if ({1'b0, w_trial} >= r_size) begin
                    n_rem = brb_pkg::CNT_W'(w_trial - r_size[brb_pkg::DATA_W-1:0]);
                end else begin
                    n_rem = w_trial[brb_pkg::CNT_W-1:0];
                end
                if (r_bit == 3'd0) begin
                    n_state = S_MOVE;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            // move the read pointer back with wrap
            S_MOVE: begin
                if ({1'b0, r_rp} >= w_rem_ext) begin
                    n_rp = brb_pkg::PTR_W'({1'b0, r_rp} - w_rem_ext);
                end else begin
                    n_rp = brb_pkg::PTR_W'({1'b0, r_rp} + r_size - w_rem_ext);
                end
                n_state = S_RWOUT;
            end
            S_RWOUT: begin
                if (w_can_emit) begin
                    n_out_vld = 1'b1;
                    n_out.data_out   = '0;
                    n_out.status     = brb_pkg::ST_OK;
                    n_out.last       = 1'b1;
                    n_out.fill_level = w_fill;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result payload and working registers
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_left   <= n_left;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_is_pop <= n_is_pop;
    end

    // control state, ring size and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_size    <= brb_pkg::SIZE_W'(MAX_N);
            r_rp      <= '0;
            r_wp      <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_size <= w_cfg_size;
                r_rp   <= '0;
                r_wp   <= '0;
            end else begin
                r_rp <= n_rp;
                r_wp <= n_wp;
            end
        end
    end

endmodule

### tb/sv/tb.sv
// tb: self-checking testbench for the byte ring buffer core with peek, pop, burst and rewind
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 256;
    localparam int BURST_LIMIT = 64;
    localparam int DRAIN_WAIT  = 24;

    // clock, reset and block ports
    logic               clk;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [8:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    brb_pkg::t_in_item  in_item  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    brb_pkg::t_out_item out_item;

    // shadow of the ring: contents, which slots hold a real byte, pointers, size register
    logic [7:0] ring_mem     [RING_DEPTH];
    bit         ring_written [RING_DEPTH];
    int         rd_ptr;
    int         wr_ptr;
    int         ring_size_reg;

    // results still owed by the block, oldest first
    brb_pkg::t_out_item pending_results[$];

    // receiver pacing and run bookkeeping
    bit          quiet;
    int          hold_req;
    int          stall_left;
    int          run_left;
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned sizes_used;
    int unsigned op_count [8];

    byte_ring_buffer_peek_rewind_core #(
        .DEPTH     (RING_DEPTH),
        .MAX_BURST (BURST_LIMIT)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    // 2 ns clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop if the block hangs
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // ring size in effect after clamping
    function automatic int ring_eff();
        int s;
        s = ring_size_reg;
        if (s < 2) s = 2;
        if (s > brb_pkg::RING_MAX) s = brb_pkg::RING_MAX;
        if (s > RING_DEPTH) s = RING_DEPTH;
        return s;
    endfunction

    function automatic int ring_fill(int n);
        return (wr_ptr >= rd_ptr) ? (wr_ptr - rd_ptr) : (wr_ptr + n - rd_ptr);
    endfunction

    function automatic int ring_bump(int p, int n);
        return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    function automatic void push_result(int data, logic [1:0] st, bit lst, int fill);
        brb_pkg::t_out_item r;
        r.data_out   = 8'(data);
        r.status     = st;
        r.last       = lst;
        r.fill_level = 8'(fill);
        pending_results.push_back(r);
    endfunction

    // expected results of one accepted transaction, and the ring state after it
    function automatic void ring_predict(brb_pkg::t_in_item it);
        int n;
        int fill;
        int c;
        int b;
        n    = ring_eff();
        fill = ring_fill(n);
        case (it.cmd)
            brb_pkg::CMD_WRITE: begin
                if (fill >= n - 1) begin
                    push_result(0, brb_pkg::ST_FULL, 1'b1, fill);
                end else begin
                    ring_mem[wr_ptr]     = it.data_in;
                    ring_written[wr_ptr] = 1'b1;
                    wr_ptr = ring_bump(wr_ptr, n);
                    push_result(0, brb_pkg::ST_OK, 1'b1, fill + 1);
                end
            end
            brb_pkg::CMD_PEEK, brb_pkg::CMD_POP: begin
                if (fill == 0) begin
                    push_result(0, brb_pkg::ST_SHORT, 1'b1, 0);
                end else begin
                    b = ring_mem[rd_ptr];
                    if (it.cmd == brb_pkg::CMD_POP) begin
                        rd_ptr = ring_bump(rd_ptr, n);
                        fill--;
                    end
                    push_result(b, brb_pkg::ST_OK, 1'b1, fill);
                end
            end
            brb_pkg::CMD_BURST: begin
                if (it.count == 0) begin
                    push_result(0, brb_pkg::ST_OK, 1'b1, fill);
                end else if (it.count > BURST_LIMIT || it.count > fill) begin
                    push_result(0, brb_pkg::ST_SHORT, 1'b1, fill);
                end else begin
                    for (int i = 0; i < it.count; i++) begin
                        b = ring_mem[rd_ptr];
                        rd_ptr = ring_bump(rd_ptr, n);
                        fill--;
                        push_result(b, brb_pkg::ST_OK, (i + 1 == it.count), fill);
                    end
                end
            end
            brb_pkg::CMD_REWIND: begin
                c = it.count % n;
                rd_ptr = (rd_ptr >= c) ? (rd_ptr - c) : (rd_ptr + n - c);
                push_result(0, brb_pkg::ST_OK, 1'b1, ring_fill(n));
            end
            default: ;
        endcase
    endfunction

    // true when the transaction would read a slot that never held a byte
    function automatic bit hits_blank_slot(brb_pkg::t_in_item it);
        int n;
        int fill;
        n    = ring_eff();
        fill = ring_fill(n);
        if ((it.cmd == brb_pkg::CMD_PEEK || it.cmd == brb_pkg::CMD_POP) && fill > 0)
            return !ring_written[rd_ptr];
        if (it.cmd == brb_pkg::CMD_BURST && it.count != 0 && it.count <= BURST_LIMIT
                && it.count <= fill) begin
            for (int i = 0; i < it.count; i++)
                if (!ring_written[(rd_ptr + i) % n]) return 1'b1;
        end
        return 1'b0;
    endfunction

    // gap before the next transaction: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random command shaped by the current fill so that bursts mostly succeed
    function automatic brb_pkg::t_in_item pick_item(int write_pct);
        brb_pkg::t_in_item it;
        int r;
        int s;
        int top;
        top        = ring_fill(ring_eff());
        top        = (top < BURST_LIMIT) ? top : BURST_LIMIT;
        it.data_in = 8'($urandom);
        it.count   = 7'($urandom_range(0, 3));
        it.cmd     = brb_pkg::CMD_WRITE;
        if ($urandom_range(0, 99) >= write_pct) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                it.cmd = brb_pkg::CMD_PEEK;
            end else if (r < 45) begin
                it.cmd = brb_pkg::CMD_POP;
            end else if (r < 80) begin
                it.cmd = brb_pkg::CMD_BURST;
                s = $urandom_range(0, 9);
                if (s == 0) it.count = '0;
                else if (s == 1) it.count = 7'($urandom_range(0, 127));
                else if (top > 0) it.count = 7'($urandom_range(1, top));
                else it.count = 7'($urandom_range(1, 3));
            end else if (r < 94) begin
                it.cmd = brb_pkg::CMD_REWIND;
                if ($urandom_range(0, 3) == 0) it.count = 7'($urandom_range(0, 127));
                else it.count = 7'($urandom_range(0, 4));
            end else begin
                it.cmd   = 3'($urandom_range(5, 7));
                it.count = 7'($urandom);
            end
        end
        return it;
    endfunction

    // offer one transaction, wait for the handshake, predict, then maybe pause
    task automatic send_item(brb_pkg::t_in_item it);
        int gap;
        if (hits_blank_slot(it)) it.cmd = brb_pkg::CMD_WRITE;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        ring_predict(it);
        op_count[it.cmd]++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_cmd(logic [2:0] cmd, logic [7:0] data, logic [6:0] cnt);
        brb_pkg::t_in_item it;
        it.cmd     = cmd;
        it.data_in = data;
        it.count   = cnt;
        send_item(it);
    endtask

    // stop offering and let every owed result come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // write the ring size register while the block is idle
    task automatic set_ring_size(int unsigned value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= 9'(value);
        @(posedge clk);
        cfg_we        <= 1'b0;
        ring_size_reg = value & 9'h1FF;
        rd_ptr        = 0;
        wr_ptr        = 0;
        sizes_used++;
    endtask

    // receiver pacing: random stalls, a requested long hold-off, or always ready
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req != 0) begin
            out_ready  <= 1'b0;
            stall_left = hold_req - 1;
            hold_req   = 0;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if (quiet || run_left > 0) begin
            out_ready <= 1'b1;
            if (run_left > 0) run_left--;
        end else begin
            out_ready  <= 1'b0;
            stall_left = pick_stall() - 1;
            run_left   = $urandom_range(1, 20);
        end
    end

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    // compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        brb_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, out_item);
            end else begin
                want = pending_results.pop_front();
                check_field("data_out", want.data_out, out_item.data_out);
                check_field("status", want.status, out_item.status);
                check_field("last", want.last, out_item.last);
                check_field("fill_level", want.fill_level, out_item.fill_level);
                results_checked++;
            end
        end
    end

    // reads on an empty ring, a zero burst and a burst past the fill, ignored commands
    task automatic test_empty_ring();
        send_cmd(brb_pkg::CMD_PEEK, 8'h00, 7'd0);
        send_cmd(brb_pkg::CMD_POP, 8'h00, 7'd0);
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'd0);
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'd5);
        send_cmd(3'd5, 8'h00, 7'd0);
        send_cmd(3'd7, 8'hFF, 7'd127);
        send_cmd(brb_pkg::CMD_REWIND, 8'h00, 7'd0);
    endtask

    // four-slot ring: full refusal, burst limits, rewind with wrap
    task automatic test_small_ring_edges();
        set_ring_size(4);
        send_cmd(brb_pkg::CMD_WRITE, 8'h00, 7'd0);
        send_cmd(brb_pkg::CMD_WRITE, 8'hFF, 7'd0);
        send_cmd(brb_pkg::CMD_WRITE, 8'hA5, 7'd0);
        send_cmd(brb_pkg::CMD_WRITE, 8'h5A, 7'd0);
        send_cmd(brb_pkg::CMD_PEEK, 8'h00, 7'd0);
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'd65);
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'd127);
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'd3);
        send_cmd(brb_pkg::CMD_POP, 8'h00, 7'd0);
        send_cmd(brb_pkg::CMD_REWIND, 8'h00, 7'd2);
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'd2);
        send_cmd(brb_pkg::CMD_REWIND, 8'h00, 7'd127);
        send_cmd(brb_pkg::CMD_POP, 8'h00, 7'd0);
    endtask

    // sizes below and above the legal range are clamped
    task automatic test_clamped_sizes();
        set_ring_size(0);
        send_cmd(brb_pkg::CMD_WRITE, 8'h3C, 7'd0);
        send_cmd(brb_pkg::CMD_WRITE, 8'hC3, 7'd0);
        send_cmd(brb_pkg::CMD_POP, 8'h00, 7'd0);
        send_cmd(brb_pkg::CMD_REWIND, 8'h00, 7'd1);
        send_cmd(brb_pkg::CMD_PEEK, 8'h00, 7'd0);
        set_ring_size(511);
        send_cmd(brb_pkg::CMD_REWIND, 8'h00, 7'd1);
        send_cmd(brb_pkg::CMD_WRITE, 8'h81, 7'd0);
    endtask

    // receiver holds off while writes keep coming, then full-length bursts
    task automatic test_backpressure();
        set_ring_size(256);
        quiet    = 1'b1;
        hold_req = 150;
        for (int i = 0; i < 70; i++)
            send_cmd(brb_pkg::CMD_WRITE, 8'($urandom), 7'($urandom));
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'(BURST_LIMIT));
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'(BURST_LIMIT + 1));
        send_cmd(brb_pkg::CMD_REWIND, 8'h00, 7'(BURST_LIMIT));
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'(BURST_LIMIT));
        send_cmd(brb_pkg::CMD_BURST, 8'h00, 7'd0);
        quiet = 1'b0;
    endtask

    // random command streams over a spread of ring sizes
    task automatic test_random_sizes();
        int unsigned       sizes [7];
        int                done;
        brb_pkg::t_in_item it;
        sizes = '{1, 2, 3, 7, 256, 0, 17};
        sizes[5] = $urandom_range(2, 300);
        for (int ph = 0; ph < 7; ph++) begin
            set_ring_size(sizes[ph]);
            quiet = (ph % 3 == 2);
            done  = 0;
            while (done < 34) begin
                it = pick_item((sizes[ph] >= 200) ? 60 : 45);
                if (it.cmd <= brb_pkg::CMD_REWIND) done++;
                send_item(it);
            end
        end
        quiet = 1'b0;
    endtask

    // test sequence
    initial begin
        ring_size_reg = 256;
        rd_ptr        = 0;
        wr_ptr        = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_small_ring_edges();
        test_clamped_sizes();
        test_backpressure();
        test_random_sizes();
        wait_idle();

        $display("run covered %0d writes, %0d peeks, %0d pops, %0d bursts, %0d rewinds",
                 op_count[brb_pkg::CMD_WRITE], op_count[brb_pkg::CMD_PEEK],
                 op_count[brb_pkg::CMD_POP], op_count[brb_pkg::CMD_BURST],
                 op_count[brb_pkg::CMD_REWIND]);
        $display("%0d results compared across %0d ring size settings, %0d field mismatches",
                 results_checked, sizes_used, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
